FILE: rtl/pfr_pkg.sv
`default_nettype none
package pfr_pkg;

  localparam int DATA_DEPTH = 1024;
  localparam int MAX_PACKET = 64;
  localparam int DESC_DEPTH = 16;

  localparam int DATA_AW = $clog2(DATA_DEPTH);
  localparam int USED_W  = $clog2(DATA_DEPTH + 1);
  localparam int SUM_W   = USED_W + 1;
  localparam int LEN_W   = $clog2(MAX_PACKET + 1);
  localparam int DESC_AW = $clog2(DESC_DEPTH);
  localparam int DCNT_W  = $clog2(DESC_DEPTH + 1);

  localparam int OP_W     = 2;
  localparam int BYTE_W   = 8;
  localparam int DCOUNT_W = 16;
  localparam int ID_W     = 32;
  localparam int BSIZE_W  = 16;
  localparam int STATUS_W = 3;
  localparam int OCOUNT_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_END   = 2'd1,
    OP_POP   = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_MISMATCH = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_TOO_BIG  = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_e;

  typedef struct packed {
    logic accept;
    logic stream;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pop_stream;
    logic stream_done;
  } dp_stat_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [ID_W-1:0]  id;
  } desc_t;

  function automatic logic [DATA_AW-1:0] data_next(input logic [DATA_AW-1:0] p);
    logic [DATA_AW-1:0] r;
    r = (p == DATA_AW'(DATA_DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  function automatic logic [DESC_AW-1:0] desc_next(input logic [DESC_AW-1:0] p);
    logic [DESC_AW-1:0] r;
    r = (p == DESC_AW'(DESC_DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/pfr_ctrl.sv
`default_nettype none
module pfr_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire pfr_pkg::dp_stat_t  stat_i,
  output pfr_pkg::ctrl_cmd_t      cmd_o,
  output logic                    busy_o
);

  typedef enum logic {
    S_IDLE,
    S_STREAM
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  always_comb begin
    cmd_o.accept = start_i && !busy_q;
    cmd_o.stream = (state_q == S_STREAM);
    state_d      = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_o.accept && stat_i.pop_stream) begin
          state_d = S_STREAM;
        end
      end
      S_STREAM: begin
        if (stat_i.stream_done) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d == S_STREAM);
    end
  end

  assign busy_o = busy_q;

endmodule
`default_nettype wire

FILE: rtl/pfr_datapath.sv
`default_nettype none
module pfr_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire pfr_pkg::ctrl_cmd_t            cmd_i,
  input  wire logic [pfr_pkg::OP_W-1:0]      operation_i,
  input  wire logic [pfr_pkg::BYTE_W-1:0]    data_byte_i,
  input  wire logic [pfr_pkg::DCOUNT_W-1:0]  declared_count_i,
  input  wire logic [pfr_pkg::ID_W-1:0]      packet_id_i,
  input  wire logic [pfr_pkg::BSIZE_W-1:0]   buffer_size_i,
  output pfr_pkg::dp_stat_t                  stat_o,
  output logic                               done_o,
  output logic [pfr_pkg::STATUS_W-1:0]       status_o,
  output logic                               data_valid_o,
  output logic [pfr_pkg::BYTE_W-1:0]         out_byte_o,
  output logic [pfr_pkg::ID_W-1:0]           out_id_o,
  output logic [pfr_pkg::OCOUNT_W-1:0]       out_count_o,
  output logic                               last_o
);

  // byte store and descriptor queue
  logic [pfr_pkg::BYTE_W-1:0] mem [pfr_pkg::DATA_DEPTH];
  pfr_pkg::desc_t             desc_mem [pfr_pkg::DESC_DEPTH];
  logic [pfr_pkg::BYTE_W-1:0] rdata_q;

  logic [pfr_pkg::DATA_AW-1:0] rp_q, rp_d, ct_q, ct_d, tt_q, tt_d;
  logic [pfr_pkg::USED_W-1:0]  used_q, used_d;
  logic [pfr_pkg::LEN_W-1:0]   plen_q, plen_d;
  logic                        povf_q, povf_d;
  logic [pfr_pkg::DESC_AW-1:0] dh_q, dh_d, dt_q, dt_d;
  logic [pfr_pkg::DCNT_W-1:0]  dcnt_q, dcnt_d;
  logic [pfr_pkg::LEN_W-1:0]   cnt_q, cnt_d;

  logic                         done_q, done_d, dv_q, dv_d, last_q, last_d;
  pfr_pkg::status_e             status_q, status_d;
  logic [pfr_pkg::ID_W-1:0]     id_q, id_d;
  logic [pfr_pkg::LEN_W-1:0]    count_q, count_d;

  logic                         byte_we, desc_we;
  pfr_pkg::op_e                 op;
  pfr_pkg::desc_t               head;
  logic [pfr_pkg::SUM_W-1:0]    fill;
  logic                         push_ovf, desc_full, too_big;

  assign op        = pfr_pkg::op_e'(operation_i);
  assign head      = desc_mem[dh_q];
  assign fill      = pfr_pkg::SUM_W'(used_q) + pfr_pkg::SUM_W'(plen_q);
  assign push_ovf  = povf_q || (plen_q >= pfr_pkg::LEN_W'(pfr_pkg::MAX_PACKET))
                     || (fill >= pfr_pkg::SUM_W'(pfr_pkg::DATA_DEPTH));
  assign desc_full = (dcnt_q >= pfr_pkg::DCNT_W'(pfr_pkg::DESC_DEPTH));
  assign too_big   = pfr_pkg::BSIZE_W'(head.len) > buffer_size_i;

  assign stat_o.pop_stream  = (op == pfr_pkg::OP_POP) && (dcnt_q != '0) && !too_big
                              && (head.len > pfr_pkg::LEN_W'(1));
  assign stat_o.stream_done = (cnt_q == pfr_pkg::LEN_W'(1));

  always_comb begin
    rp_d     = rp_q;
    ct_d     = ct_q;
    tt_d     = tt_q;
    used_d   = used_q;
    plen_d   = plen_q;
    povf_d   = povf_q;
    dh_d     = dh_q;
    dt_d     = dt_q;
    dcnt_d   = dcnt_q;
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    dv_d     = 1'b0;
    last_d   = 1'b1;
    status_d = pfr_pkg::ST_OK;
    id_d     = '0;
    count_d  = '0;
    byte_we  = 1'b0;
    desc_we  = 1'b0;
    if (cmd_i.stream) begin
      done_d  = 1'b1;
      dv_d    = 1'b1;
      id_d    = id_q;
      count_d = count_q;
      last_d  = (cnt_q == pfr_pkg::LEN_W'(1));
      cnt_d   = cnt_q - 1'b1;
      rp_d    = pfr_pkg::data_next(rp_q);
    end else if (cmd_i.accept) begin
      done_d = 1'b1;
      case (op)
        pfr_pkg::OP_PUSH: begin
          if (push_ovf) begin
            povf_d   = 1'b1;
            status_d = pfr_pkg::ST_OVERFLOW;
          end else begin
            byte_we = 1'b1;
            tt_d    = pfr_pkg::data_next(tt_q);
            plen_d  = plen_q + 1'b1;
          end
        end
        pfr_pkg::OP_END: begin
          if (povf_q) begin
            status_d = pfr_pkg::ST_OVERFLOW;
          end else if (declared_count_i != pfr_pkg::DCOUNT_W'(plen_q)) begin
            status_d = pfr_pkg::ST_MISMATCH;
          end else if (desc_full) begin
            status_d = pfr_pkg::ST_OVERFLOW;
          end
          if (!povf_q && (declared_count_i == pfr_pkg::DCOUNT_W'(plen_q)) && !desc_full) begin
            desc_we = 1'b1;
            dt_d    = pfr_pkg::desc_next(dt_q);
            dcnt_d  = dcnt_q + 1'b1;
            ct_d    = tt_q;
            used_d  = used_q + pfr_pkg::USED_W'(plen_q);
          end else begin
            tt_d = ct_q;
          end
          plen_d = '0;
          povf_d = 1'b0;
        end
        pfr_pkg::OP_POP: begin
          if (dcnt_q == '0) begin
            status_d = pfr_pkg::ST_EMPTY;
          end else if (too_big) begin
            status_d = pfr_pkg::ST_TOO_BIG;
            id_d     = head.id;
            count_d  = head.len;
          end else begin
            dh_d   = pfr_pkg::desc_next(dh_q);
            dcnt_d = dcnt_q - 1'b1;
            id_d   = head.id;
            if (head.len != '0) begin
              dv_d    = 1'b1;
              count_d = head.len;
              last_d  = (head.len == pfr_pkg::LEN_W'(1));
              cnt_d   = head.len - 1'b1;
              rp_d    = pfr_pkg::data_next(rp_q);
              used_d  = (used_q >= pfr_pkg::USED_W'(head.len))
                        ? used_q - pfr_pkg::USED_W'(head.len) : '0;
            end
          end
        end
        pfr_pkg::OP_CLEAR: begin
          rp_d   = '0;
          ct_d   = '0;
          tt_d   = '0;
          used_d = '0;
          plen_d = '0;
          povf_d = 1'b0;
          dh_d   = '0;
          dt_d   = '0;
          dcnt_d = '0;
        end
        default: status_d = pfr_pkg::ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_we) begin
      mem[tt_q] <= data_byte_i;
    end
    rdata_q <= mem[rp_q];
  end

  always_ff @(posedge clk_i) begin
    if (desc_we) begin
      desc_mem[dt_q] <= '{len: plen_q, id: packet_id_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q     <= '0;
      ct_q     <= '0;
      tt_q     <= '0;
      used_q   <= '0;
      plen_q   <= '0;
      povf_q   <= 1'b0;
      dh_q     <= '0;
      dt_q     <= '0;
      dcnt_q   <= '0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      dv_q     <= 1'b0;
      last_q   <= 1'b0;
      status_q <= pfr_pkg::ST_OK;
      id_q     <= '0;
      count_q  <= '0;
    end else begin
      rp_q     <= rp_d;
      ct_q     <= ct_d;
      tt_q     <= tt_d;
      used_q   <= used_d;
      plen_q   <= plen_d;
      povf_q   <= povf_d;
      dh_q     <= dh_d;
      dt_q     <= dt_d;
      dcnt_q   <= dcnt_d;
      cnt_q    <= cnt_d;
      done_q   <= done_d;
      dv_q     <= dv_d;
      last_q   <= last_d;
      status_q <= status_d;
      id_q     <= id_d;
      count_q  <= count_d;
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign data_valid_o = dv_q;
  assign out_byte_o   = dv_q ? rdata_q : '0;
  assign out_id_o     = id_q;
  assign out_count_o  = pfr_pkg::OCOUNT_W'(count_q);
  assign last_o       = last_q;

endmodule
`default_nettype wire

FILE: rtl/packet_fifo_with_rollback.sv
`default_nettype none
// channel   handshake             payload
// command   start_i / busy_o      operation_i, data_byte_i, declared_count_i,
//                                 packet_id_i, buffer_size_i
// result    done_o (one cycle)    status_o, data_valid_o, out_byte_o, out_id_o,
//                                 out_count_o, last_o
//
// every transaction gives its first result in the cycle after it is taken
// push, end, clear, rejected pops and pops of at most one byte give one result; busy_o stays low
// a pop of n bytes streams one byte per cycle from the byte store read port,
// busy_o high while all but the last of its bytes are on the result channel
// reset is asynchronous and active low; no clearing pass, ready at once
// the receiver cannot stall results
module packet_fifo_with_rollback (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [pfr_pkg::OP_W-1:0]      operation_i,
  input  wire logic [pfr_pkg::BYTE_W-1:0]    data_byte_i,
  input  wire logic [pfr_pkg::DCOUNT_W-1:0]  declared_count_i,
  input  wire logic [pfr_pkg::ID_W-1:0]      packet_id_i,
  input  wire logic [pfr_pkg::BSIZE_W-1:0]   buffer_size_i,
  output logic                               done_o,
  output logic [pfr_pkg::STATUS_W-1:0]       status_o,
  output logic                               data_valid_o,
  output logic [pfr_pkg::BYTE_W-1:0]         out_byte_o,
  output logic [pfr_pkg::ID_W-1:0]           out_id_o,
  output logic [pfr_pkg::OCOUNT_W-1:0]       out_count_o,
  output logic                               last_o
);

  pfr_pkg::ctrl_cmd_t cmd;
  pfr_pkg::dp_stat_t  stat;

  pfr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  pfr_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .operation_i     (operation_i),
    .data_byte_i     (data_byte_i),
    .declared_count_i(declared_count_i),
    .packet_id_i     (packet_id_i),
    .buffer_size_i   (buffer_size_i),
    .stat_o          (stat),
    .done_o          (done_o),
    .status_o        (status_o),
    .data_valid_o    (data_valid_o),
    .out_byte_o      (out_byte_o),
    .out_id_o        (out_id_o),
    .out_count_o     (out_count_o),
    .last_o          (last_o)
  );

  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> done_o)
    else $error("accepted transaction gave no result");

  a_busy_streams: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> done_o && data_valid_o)
    else $error("busy without a streamed byte");

  a_stream_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && data_valid_o && !last_o |=> done_o && data_valid_o && $stable(out_id_o))
    else $error("packet stream broken");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !data_valid_o |-> last_o && !busy_o)
    else $error("non-stream result not final");

endmodule
`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;

  typedef struct {
    pfr_pkg::status_e                  status;
    bit                                has_data;
    logic [pfr_pkg::BYTE_W-1:0]        data;
    logic [pfr_pkg::ID_W-1:0]          pid;
    logic [pfr_pkg::OCOUNT_W-1:0]      count;
    bit                                last;
  } fifo_result_t;

  typedef struct {
    pfr_pkg::op_e                      op;
    logic [pfr_pkg::BYTE_W-1:0]        data;
    logic [pfr_pkg::DCOUNT_W-1:0]      declared;
    logic [pfr_pkg::ID_W-1:0]          pid;
    logic [pfr_pkg::BSIZE_W-1:0]       bufsize;
    bit                                fixed;
    pfr_pkg::status_e                  status;
  } stim_row_t;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              start_i;
  logic                              busy_o;
  pfr_pkg::op_e                      operation_i;
  logic [pfr_pkg::BYTE_W-1:0]        data_byte_i;
  logic [pfr_pkg::DCOUNT_W-1:0]      declared_count_i;
  logic [pfr_pkg::ID_W-1:0]          packet_id_i;
  logic [pfr_pkg::BSIZE_W-1:0]       buffer_size_i;
  logic                              done_o;
  logic [pfr_pkg::STATUS_W-1:0]      status_o;
  logic                              data_valid_o;
  logic [pfr_pkg::BYTE_W-1:0]        out_byte_o;
  logic [pfr_pkg::ID_W-1:0]          out_id_o;
  logic [pfr_pkg::OCOUNT_W-1:0]      out_count_o;
  logic                              last_o;

  packet_fifo_with_rollback dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .operation_i      (operation_i),
    .data_byte_i      (data_byte_i),
    .declared_count_i (declared_count_i),
    .packet_id_i      (packet_id_i),
    .buffer_size_i    (buffer_size_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .data_valid_o     (data_valid_o),
    .out_byte_o       (out_byte_o),
    .out_id_o         (out_id_o),
    .out_count_o      (out_count_o),
    .last_o           (last_o)
  );

  // mirror of the fifo state
  logic [pfr_pkg::BYTE_W-1:0]   fifo_store [pfr_pkg::DATA_DEPTH];
  logic [pfr_pkg::DATA_AW-1:0]  rd_ptr;
  logic [pfr_pkg::DATA_AW-1:0]  commit_tail;
  logic [pfr_pkg::DATA_AW-1:0]  write_tail;
  logic [pfr_pkg::USED_W-1:0]   used_bytes;
  logic [pfr_pkg::LEN_W-1:0]    open_len;
  logic                         open_overflow;
  logic [pfr_pkg::LEN_W-1:0]    desc_len [pfr_pkg::DESC_DEPTH];
  logic [pfr_pkg::ID_W-1:0]     desc_pid [pfr_pkg::DESC_DEPTH];
  logic [pfr_pkg::DESC_AW-1:0]  q_head;
  logic [pfr_pkg::DESC_AW-1:0]  q_tail;
  logic [pfr_pkg::DCNT_W-1:0]   q_count;

  fifo_result_t awaited_results [$];
  int           fault_count = 0;
  int           items_sent = 0;
  bit           no_gap = 1'b0;

  stim_row_t directed_rows [24] = '{
    '{pfr_pkg::OP_POP,   8'h00, 16'h0000, 32'h0000_0000, 16'hFFFF, 1'b1, pfr_pkg::ST_EMPTY},
    '{pfr_pkg::OP_END,   8'h00, 16'h0000, 32'hFFFF_FFFF, 16'h0000, 1'b1, pfr_pkg::ST_OK},
    '{pfr_pkg::OP_POP,   8'h00, 16'h0000, 32'h0000_0000, 16'h0000, 1'b0, pfr_pkg::ST_OK},
    '{pfr_pkg::OP_PUSH,  8'h00, 16'h0000, 32'h0000_0000, 16'h0000, 1'b1, pfr_pkg::ST_OK},
    '{pfr_pkg::OP_PUSH,  8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, pfr_pkg::ST_OK},
    '{pfr_pkg::OP_PUSH,  8'hA5, 16'h0000, 32'h0000_0000, 16'h0000, 1'b1, pfr_pkg::ST_OK},
    '{pfr_pkg::OP_END,   8'h00, 16'h0003, 32'h0000_0000, 16'h0000, 1'b1, pfr_pkg::ST_OK},
    '{pfr_pkg::OP_PUSH,  8'h5A, 16'h0000, 32'h0000_0000, 16'h0000, 1'b1, pfr_pkg::ST_OK},
    '{pfr_pkg::OP_PUSH,  8'h3C, 16'h0000, 32'h0000_0000, 16'h0000, 1'b1, pfr_pkg::ST_OK},
    '{pfr_pkg::OP_END,   8'h00, 16'hFFFF, 32'h0000_0001, 16'h0000, 1'b1,
      pfr_pkg::ST_MISMATCH},
    '{pfr_pkg::OP_PUSH,  8'h81, 16'h0000, 32'h0000_0000, 16'h0000, 1'b1, pfr_pkg::ST_OK},
    '{pfr_pkg::OP_END,   8'h00, 16'h0001, 32'h1234_5678, 16'h0000, 1'b1, pfr_pkg::ST_OK},
    '{pfr_pkg::OP_POP,   8'h00, 16'h0000, 32'h0000_0000, 16'h0002, 1'b0, pfr_pkg::ST_OK},
    '{pfr_pkg::OP_POP,   8'h00, 16'h0000, 32'h0000_0000, 16'h0003, 1'b0, pfr_pkg::ST_OK},
    '{pfr_pkg::OP_POP,   8'h00, 16'h0000, 32'h0000_0000, 16'hFFFF, 1'b0, pfr_pkg::ST_OK},
    '{pfr_pkg::OP_POP,   8'h00, 16'h0000, 32'h0000_0000, 16'hFFFF, 1'b1, pfr_pkg::ST_EMPTY},
    '{pfr_pkg::OP_PUSH,  8'h7E, 16'h0000, 32'h0000_0000, 16'h0000, 1'b1, pfr_pkg::ST_OK},
    '{pfr_pkg::OP_PUSH,  8'h01, 16'h0000, 32'h0000_0000, 16'h0000, 1'b1, pfr_pkg::ST_OK},
    '{pfr_pkg::OP_END,   8'h00, 16'h0002, 32'hDEAD_BEEF, 16'h0000, 1'b1, pfr_pkg::ST_OK},
    '{pfr_pkg::OP_PUSH,  8'h55, 16'h0000, 32'h0000_0000, 16'h0000, 1'b1, pfr_pkg::ST_OK},
    '{pfr_pkg::OP_CLEAR, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, pfr_pkg::ST_OK},
    '{pfr_pkg::OP_POP,   8'h00, 16'h0000, 32'h0000_0000, 16'hFFFF, 1'b1, pfr_pkg::ST_EMPTY},
    '{pfr_pkg::OP_END,   8'h00, 16'h0000, 32'h0000_0001, 16'h0000, 1'b1, pfr_pkg::ST_OK},
    '{pfr_pkg::OP_POP,   8'h00, 16'h0000, 32'h0000_0000, 16'h0000, 1'b0, pfr_pkg::ST_OK}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic mirror_reset();
    rd_ptr        = '0;
    commit_tail   = '0;
    write_tail    = '0;
    used_bytes    = '0;
    open_len      = '0;
    open_overflow = 1'b0;
    q_head        = '0;
    q_tail        = '0;
    q_count       = '0;
  endtask

  task automatic add_result(fifo_result_t r);
    awaited_results.insert(awaited_results.size(), r);
  endtask

  task automatic predict_transaction(pfr_pkg::op_e op, logic [pfr_pkg::BYTE_W-1:0] data,
                                     logic [pfr_pkg::DCOUNT_W-1:0] declared,
                                     logic [pfr_pkg::ID_W-1:0] pid,
                                     logic [pfr_pkg::BSIZE_W-1:0] bufsize);
    pfr_pkg::status_e          st;
    logic [pfr_pkg::LEN_W-1:0] len;
    logic [pfr_pkg::ID_W-1:0]  head_pid;
    case (op)
      pfr_pkg::OP_PUSH: begin
        if (!open_overflow && (int'(open_len) >= pfr_pkg::MAX_PACKET ||
            int'(used_bytes) + int'(open_len) >= pfr_pkg::DATA_DEPTH))
          open_overflow = 1'b1;
        if (open_overflow) begin
          add_result(fifo_result_t'{pfr_pkg::ST_OVERFLOW, 1'b0, '0, '0, '0, 1'b1});
        end else begin
          fifo_store[write_tail] = data;
          write_tail = pfr_pkg::DATA_AW'((int'(write_tail) + 1) % pfr_pkg::DATA_DEPTH);
          open_len++;
          add_result(fifo_result_t'{pfr_pkg::ST_OK, 1'b0, '0, '0, '0, 1'b1});
        end
      end
      pfr_pkg::OP_END: begin
        if (open_overflow)
          st = pfr_pkg::ST_OVERFLOW;
        else if (int'(declared) != int'(open_len))
          st = pfr_pkg::ST_MISMATCH;
        else if (int'(q_count) >= pfr_pkg::DESC_DEPTH)
          st = pfr_pkg::ST_OVERFLOW;
        else
          st = pfr_pkg::ST_OK;
        if (st == pfr_pkg::ST_OK) begin
          desc_len[q_tail] = open_len;
          desc_pid[q_tail] = pid;
          q_tail = pfr_pkg::DESC_AW'((int'(q_tail) + 1) % pfr_pkg::DESC_DEPTH);
          q_count++;
          commit_tail = write_tail;
          used_bytes  = used_bytes + pfr_pkg::USED_W'(open_len);
        end else begin
          write_tail = commit_tail;
        end
        open_len      = '0;
        open_overflow = 1'b0;
        add_result(fifo_result_t'{st, 1'b0, '0, '0, '0, 1'b1});
      end
      pfr_pkg::OP_POP: begin
        if (q_count == '0) begin
          add_result(fifo_result_t'{pfr_pkg::ST_EMPTY, 1'b0, '0, '0, '0, 1'b1});
        end else begin
          len      = desc_len[q_head];
          head_pid = desc_pid[q_head];
          if (int'(len) > int'(bufsize)) begin
            add_result(fifo_result_t'{pfr_pkg::ST_TOO_BIG, 1'b0, '0, head_pid,
                                      pfr_pkg::OCOUNT_W'(len), 1'b1});
          end else begin
            q_head = pfr_pkg::DESC_AW'((int'(q_head) + 1) % pfr_pkg::DESC_DEPTH);
            q_count--;
            if (len == '0)
              add_result(fifo_result_t'{pfr_pkg::ST_OK, 1'b0, '0, head_pid, '0, 1'b1});
            for (int i = 0; i < int'(len); i++) begin
              add_result(fifo_result_t'{pfr_pkg::ST_OK, 1'b1, fifo_store[rd_ptr], head_pid,
                                        pfr_pkg::OCOUNT_W'(len), (i + 1 == int'(len))});
              rd_ptr = pfr_pkg::DATA_AW'((int'(rd_ptr) + 1) % pfr_pkg::DATA_DEPTH);
            end
            used_bytes = (used_bytes >= pfr_pkg::USED_W'(len))
                         ? used_bytes - pfr_pkg::USED_W'(len) : '0;
          end
        end
      end
      default: begin
        mirror_reset();
        add_result(fifo_result_t'{pfr_pkg::ST_OK, 1'b0, '0, '0, '0, 1'b1});
      end
    endcase
  endtask

  task automatic send_item(pfr_pkg::op_e op, logic [pfr_pkg::BYTE_W-1:0] data,
                           logic [pfr_pkg::DCOUNT_W-1:0] declared,
                           logic [pfr_pkg::ID_W-1:0] pid,
                           logic [pfr_pkg::BSIZE_W-1:0] bufsize, bit fixed,
                           pfr_pkg::status_e st);
    int n0;
    int gap;
    operation_i      <= op;
    data_byte_i      <= data;
    declared_count_i <= declared;
    packet_id_i      <= pid;
    buffer_size_i    <= bufsize;
    start_i          <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    n0 = awaited_results.size();
    predict_transaction(op, data, declared, pid, bufsize);
    if (fixed) begin
      while (awaited_results.size() > n0) void'(awaited_results.pop_back());
      add_result(fifo_result_t'{st, 1'b0, '0, '0, '0, 1'b1});
    end
    items_sent++;
    if ($urandom_range(0, 19) == 0) no_gap = !no_gap;
    gap = no_gap ? 0 : int'($urandom_range(0, 14));
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_packet(int len, logic [pfr_pkg::DCOUNT_W-1:0] declared,
                             logic [pfr_pkg::ID_W-1:0] pid);
    for (int i = 0; i < len; i++)
      send_item(pfr_pkg::OP_PUSH, pfr_pkg::BYTE_W'($urandom), pfr_pkg::DCOUNT_W'($urandom),
                $urandom, pfr_pkg::BSIZE_W'($urandom), 1'b0, pfr_pkg::ST_OK);
    send_item(pfr_pkg::OP_END, pfr_pkg::BYTE_W'($urandom), declared, pid,
              pfr_pkg::BSIZE_W'($urandom), 1'b0, pfr_pkg::ST_OK);
  endtask

  task automatic send_pop();
    int len;
    int r;
    logic [pfr_pkg::BSIZE_W-1:0] bufsize;
    len = (q_count != '0) ? int'(desc_len[q_head]) : 0;
    r = int'($urandom_range(0, 99));
    if (r < 60)
      bufsize = pfr_pkg::BSIZE_W'($urandom_range(len, 65535));
    else if (r < 85)
      bufsize = (len == 0) ? '0 : pfr_pkg::BSIZE_W'($urandom_range(0, len - 1));
    else
      bufsize = pfr_pkg::BSIZE_W'($urandom);
    send_item(pfr_pkg::OP_POP, pfr_pkg::BYTE_W'($urandom), pfr_pkg::DCOUNT_W'($urandom),
              $urandom, bufsize, 1'b0, pfr_pkg::ST_OK);
  endtask

  task automatic random_traffic(int n);
    int base;
    int r;
    int len;
    logic [pfr_pkg::DCOUNT_W-1:0] declared;
    base = items_sent;
    while (items_sent - base < n) begin
      r = int'($urandom_range(0, 99));
      if (r < 45) begin
        r = int'($urandom_range(0, 99));
        if (r < 70)
          len = int'($urandom_range(0, 6));
        else if (r < 90)
          len = int'($urandom_range(7, 24));
        else if (r < 95)
          len = pfr_pkg::MAX_PACKET;
        else
          len = int'($urandom_range(pfr_pkg::MAX_PACKET + 1, pfr_pkg::MAX_PACKET + 3));
        r = int'($urandom_range(0, 99));
        if (r < 75)
          declared = pfr_pkg::DCOUNT_W'(len);
        else if (r < 85)
          declared = pfr_pkg::DCOUNT_W'(len + 1);
        else if (r < 92)
          declared = pfr_pkg::DCOUNT_W'(len - 1);
        else
          declared = pfr_pkg::DCOUNT_W'($urandom);
        send_packet(len, declared, $urandom);
      end else if (r < 85) begin
        send_pop();
      end else if (r < 88) begin
        send_item(pfr_pkg::OP_CLEAR, pfr_pkg::BYTE_W'($urandom),
                  pfr_pkg::DCOUNT_W'($urandom), $urandom, pfr_pkg::BSIZE_W'($urandom),
                  1'b0, pfr_pkg::ST_OK);
      end else begin
        send_item(pfr_pkg::op_e'($urandom_range(0, 2)), pfr_pkg::BYTE_W'($urandom),
                  pfr_pkg::DCOUNT_W'($urandom), $urandom, pfr_pkg::BSIZE_W'($urandom),
                  1'b0, pfr_pkg::ST_OK);
      end
    end
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fault_count++;
    end
  endtask

  always @(posedge clk_i) begin
    fifo_result_t want;
    if (rst_ni && done_o) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected transaction result: status %0d byte %0h", status_o,
               out_byte_o);
        fault_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("data_valid", 32'(want.has_data), 32'(data_valid_o));
        check_field("out_byte", 32'(want.data), 32'(out_byte_o));
        check_field("out_id", want.pid, out_id_o);
        check_field("out_count", 32'(want.count), 32'(out_count_o));
        check_field("last", 32'(want.last), 32'(last_o));
      end
    end
  end

  initial begin
    rst_ni           <= 1'b0;
    start_i          <= 1'b0;
    operation_i      <= pfr_pkg::OP_PUSH;
    data_byte_i      <= '0;
    declared_count_i <= '0;
    packet_id_i      <= '0;
    buffer_size_i    <= '0;
    mirror_reset();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[k])
      send_item(directed_rows[k].op, directed_rows[k].data, directed_rows[k].declared,
                directed_rows[k].pid, directed_rows[k].bufsize, directed_rows[k].fixed,
                directed_rows[k].status);

    random_traffic(15);
    wait_idle();

    // packet one past the limit, then one of exactly the limit
    send_packet(pfr_pkg::MAX_PACKET + 1, pfr_pkg::DCOUNT_W'(pfr_pkg::MAX_PACKET), $urandom);
    send_packet(pfr_pkg::MAX_PACKET, pfr_pkg::DCOUNT_W'(pfr_pkg::MAX_PACKET), $urandom);
    while (q_count != '0)
      send_item(pfr_pkg::OP_POP, pfr_pkg::BYTE_W'($urandom), pfr_pkg::DCOUNT_W'($urandom),
                $urandom, 16'hFFFF, 1'b0, pfr_pkg::ST_OK);

    // fill the descriptor queue, then end two packets against it
    for (int k = 0; k < pfr_pkg::DESC_DEPTH; k++)
      send_packet((k + 1) % 2, pfr_pkg::DCOUNT_W'((k + 1) % 2), $urandom);
    send_packet(2, 16'd2, $urandom);
    send_packet(0, 16'd0, $urandom);
    send_item(pfr_pkg::OP_POP, pfr_pkg::BYTE_W'($urandom), pfr_pkg::DCOUNT_W'($urandom),
              $urandom, 16'h0000, 1'b0, pfr_pkg::ST_OK);
    while (q_count != '0)
      send_item(pfr_pkg::OP_POP, pfr_pkg::BYTE_W'($urandom), pfr_pkg::DCOUNT_W'($urandom),
                $urandom, pfr_pkg::BSIZE_W'(pfr_pkg::MAX_PACKET), 1'b0, pfr_pkg::ST_OK);

    random_traffic(15);

    wait_idle();
    repeat (2 * pfr_pkg::MAX_PACKET) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
